// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, checked on every rising clock edge outside reset.
`define IDA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked on every rising clock edge outside reset.
`define IDA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== design/ida_pkg.sv =====
// Package with the constants and control types of the I-divergence accumulator.
package ida_pkg;
   localparam int DEF_FRAC_BITS  = 16;
   localparam int DEF_COUNT_BITS = 32;
   localparam int SAMPLE_BITS    = 32;
   localparam int ACC_BITS       = 64;
   localparam int LOG_FRAC_BITS  = 24;
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   typedef struct packed {
      logic load;
      logic norm;
      logic sq_step;
      logic ln_calc;
      logic prod_calc;
      logic add_term;
      logic add_y;
      logic div_init;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic log_path;
      logic mask;
      logic last;
      logic count_zero;
      logic out_full;
   } status_type;
endpackage

// ===== design/ida_if.sv =====
// Stream interfaces for the pixel input and the result output.
interface ida_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] x_sample;
   logic [31:0] y_sample;
   logic        mask_bit;
   logic        last_pixel;
   modport source (output valid, x_sample, y_sample, mask_bit, last_pixel, input ready);
   modport sink   (input valid, x_sample, y_sample, mask_bit, last_pixel, output ready);
endinterface

interface ida_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] mean_divergence;
   logic [31:0]        pixel_total;
   logic               saturated;
   modport source (output valid, mean_divergence, pixel_total, saturated, input ready);
   modport sink   (input valid, mean_divergence, pixel_total, saturated, output ready);
endinterface

// ===== design/i_divergence_accumulator_unit.sv =====
// Top level of the I-divergence accumulator.
// Usage: pixel pairs (x test, y reference, unsigned Q16.16) arrive on req_chan
// with a mask bit and a last-pixel flag; a transfer happens when valid and ready
// are both high. One result per image leaves on rsp_chan after the last pixel:
// the mean x*ln(x/y) - x + y over the masked pixels in signed Q32.32, the
// pixel count and a sticky clip flag.
// Sequence: the unit takes no new pixel until it is through with the last one.
// A masked pixel with both samples nonzero runs the 24 squaring steps of the
// log2 unit, then the ln, product, term-add and y-add states; a pixel with a
// zero sample only adds y, and an unmasked one adds nothing. The last pixel
// then runs the 64 steps of the one-bit-per-cycle divider and loads the result
// register. When the image counted no pixel the divider is skipped.
// Reset clears the sum, the count, the clip flag and the result valid flag.
// The result sits in an output register; a stalled receiver holds it while the
// next image is accumulated, and only the next result load waits for it.
module i_divergence_accumulator_unit #(
   parameter int FRAC_BITS  = ida_pkg::DEF_FRAC_BITS,
   parameter int COUNT_BITS = ida_pkg::DEF_COUNT_BITS
) (
   input logic        clock,
   input logic        reset,
   ida_req_if.sink    req_chan,
   ida_rsp_if.source  rsp_chan
);
   import ida_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic [63:0] mean;

   ida_controller u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_chan.valid),
      .in_ready (req_chan.ready),
      .status   (status),
      .cmd      (cmd)
   );

   ida_datapath #(
      .FRAC_BITS  (FRAC_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .x_in      (req_chan.x_sample),
      .y_in      (req_chan.y_sample),
      .mask_in   (req_chan.mask_bit),
      .last_in   (req_chan.last_pixel),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_mean  (mean),
      .out_total (rsp_chan.pixel_total),
      .out_sat   (rsp_chan.saturated)
   );

   assign rsp_chan.mean_divergence = $signed(mean);
endmodule

// ===== design/ida_controller.sv =====
// Sequencer that steps the datapath through one pixel and the final division.
module ida_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  ida_pkg::status_type status,
   output ida_pkg::cmd_type    cmd
);
   import ida_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_NORM  = 4'd1;
   localparam logic [3:0] ST_LOG   = 4'd2;
   localparam logic [3:0] ST_LN    = 4'd3;
   localparam logic [3:0] ST_PROD  = 4'd4;
   localparam logic [3:0] ST_ADDT  = 4'd5;
   localparam logic [3:0] ST_ADDY  = 4'd6;
   localparam logic [3:0] ST_CHECK = 4'd7;
   localparam logic [3:0] ST_DIV   = 4'd8;
   localparam logic [3:0] ST_OUT   = 4'd9;

   localparam logic [5:0] LOG_LAST = 6'(LOG_FRAC_BITS - 1);
   localparam logic [5:0] DIV_LAST = 6'(ACC_BITS - 1);

   logic [3:0] state_ff, state_in;
   logic [5:0] iter_ff, iter_in;

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      cmd      = '0;
      in_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            // The flags of the latched pixel pick the path.
            iter_in = LOG_LAST;
            if (status.log_path) begin
               cmd.norm = 1'b1;
               state_in = ST_LOG;
            end else if (status.mask) begin
               state_in = ST_ADDY;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_LOG: begin
            cmd.sq_step = 1'b1;
            iter_in     = iter_ff - 6'd1;
            if (iter_ff == 6'd0) state_in = ST_LN;
         end
         ST_LN: begin
            cmd.ln_calc = 1'b1;
            state_in    = ST_PROD;
         end
         ST_PROD: begin
            cmd.prod_calc = 1'b1;
            state_in      = ST_ADDT;
         end
         ST_ADDT: begin
            cmd.add_term = 1'b1;
            state_in     = ST_ADDY;
         end
         ST_ADDY: begin
            cmd.add_y = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            iter_in = DIV_LAST;
            if (!status.last) begin
               state_in = ST_IDLE;
            end else if (status.count_zero) begin
               state_in = ST_OUT;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            iter_in      = iter_ff - 6'd1;
            if (iter_ff == 6'd0) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!status.out_full) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end
endmodule

// ===== design/ida_datapath.sv =====
// Datapath: log2 by squaring, ln scaling, product, saturating sum and divider.
module ida_datapath #(
   parameter int FRAC_BITS  = ida_pkg::DEF_FRAC_BITS,
   parameter int COUNT_BITS = ida_pkg::DEF_COUNT_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  ida_pkg::cmd_type    cmd,
   output ida_pkg::status_type status,
   input  logic [31:0]         x_in,
   input  logic [31:0]         y_in,
   input  logic                mask_in,
   input  logic                last_in,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [63:0]         out_mean,
   output logic [31:0]         out_total,
   output logic                out_sat
);
   import ida_pkg::*;

   localparam int SH = FRAC_BITS - 8;
   localparam int UP = 32 - FRAC_BITS;
   localparam logic [63:0] RND = (64'd1 << SH) >> 1;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   logic [31:0] x_ff, y_ff;
   logic        mask_ff, last_ff;
   logic [31:0] mx_ff, my_ff;
   logic [4:0]  px_ff, py_ff;
   logic [23:0] fx_ff, fy_ff;
   logic [29:0] lnmag_ff;
   logic        lnneg_ff;
   logic [63:0] prod_ff;
   logic [63:0] acc_ff;
   logic [COUNT_BITS-1:0] cnt_ff;
   logic        sat_ff;
   logic [63:0] q_ff;
   logic [COUNT_BITS:0] r_ff;
   logic        dneg_ff;

   function automatic logic [4:0] top_bit(input logic [31:0] v);
      logic [4:0] idx;
      idx = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) idx = 5'(i);
      end
      return idx;
   endfunction

   // Returns the overflow flag above the clipped 64-bit sum.
   function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         return {1'b1, b[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}};
      end
      return {1'b0, s};
   endfunction

   // One squaring step of each mantissa.
   logic [63:0] sqx, sqy;
   logic [32:0] tx, ty;
   assign sqx = 64'(mx_ff) * 64'(mx_ff);
   assign sqy = 64'(my_ff) * 64'(my_ff);
   assign tx  = sqx[63:31];
   assign ty  = sqy[63:31];

   logic [4:0] px_n, py_n;
   assign px_n = top_bit(x_ff);
   assign py_n = top_bit(y_ff);

   logic signed [29:0] d2;
   logic [28:0] d2mag;
   logic [60:0] lnp, lnr;
   assign d2    = $signed({1'b0, px_ff, fx_ff}) - $signed({1'b0, py_ff, fy_ff});
   assign d2mag = d2[29] ? 29'(-d2) : 29'(d2);
   assign lnp   = 61'(d2mag) * 61'(LN2_Q32);
   assign lnr   = (lnp + 61'(64'd1 << 31)) >> 32;

   logic [63:0] pp, prnd;
   assign pp   = 64'(lnmag_ff) * 64'(x_ff);
   assign prnd = (pp + RND) >> SH;

   logic [63:0] xq, yq, term;
   logic [64:0] add_t, add_y;
   assign xq    = 64'(x_ff) << UP;
   assign yq    = 64'(y_ff) << UP;
   assign term  = prod_ff - xq;
   assign add_t = sat_add(acc_ff, term);
   assign add_y = sat_add(acc_ff, yq);

   logic [COUNT_BITS:0] rs;
   logic                qbit;
   assign rs   = {r_ff[COUNT_BITS-1:0], q_ff[63]};
   assign qbit = rs >= {1'b0, cnt_ff};

   logic [COUNT_BITS+31:0] cnt_wide;
   assign cnt_wide = {32'd0, cnt_ff};

   assign status.log_path   = mask_ff && x_ff != 32'd0 && y_ff != 32'd0;
   assign status.mask       = mask_ff;
   assign status.last       = last_ff;
   assign status.count_zero = cnt_ff == '0;
   assign status.out_full   = out_valid;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         mask_ff <= mask_in;
         last_ff <= last_in;
      end
      if (cmd.norm) begin
         px_ff <= px_n;
         py_ff <= py_n;
         mx_ff <= x_ff << (5'd31 - px_n);
         my_ff <= y_ff << (5'd31 - py_n);
      end
      if (cmd.sq_step) begin
         mx_ff <= tx[32] ? tx[32:1] : tx[31:0];
         my_ff <= ty[32] ? ty[32:1] : ty[31:0];
         fx_ff <= {fx_ff[22:0], tx[32]};
         fy_ff <= {fy_ff[22:0], ty[32]};
      end
      if (cmd.ln_calc) begin
         lnmag_ff <= lnr[29:0];
         lnneg_ff <= d2[29];
      end
      if (cmd.prod_calc) prod_ff <= lnneg_ff ? -prnd : prnd;
      if (cmd.div_init) begin
         dneg_ff <= acc_ff[63];
         q_ff    <= acc_ff[63] ? -acc_ff : acc_ff;
         r_ff    <= '0;
      end
      if (cmd.div_step) begin
         q_ff <= {q_ff[62:0], qbit};
         r_ff <= qbit ? rs - {1'b0, cnt_ff} : rs;
      end
      if (cmd.out_load) begin
         out_mean  <= status.count_zero ? 64'd0 : (dneg_ff ? -q_ff : q_ff);
         out_total <= (cnt_wide[COUNT_BITS+31:32] != '0) ? 32'hFFFF_FFFF : cnt_wide[31:0];
         out_sat   <= sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         cnt_ff    <= '0;
         sat_ff    <= 1'b0;
         out_valid <= 1'b0;
      end else begin
         if (cmd.add_term) begin
            acc_ff <= add_t[63:0];
            if (add_t[64]) sat_ff <= 1'b1;
         end
         if (cmd.add_y) begin
            acc_ff <= add_y[63:0];
            if (add_y[64]) sat_ff <= 1'b1;
            if (cnt_ff != CNT_MAX) cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.out_load) begin
            acc_ff    <= '0;
            cnt_ff    <= '0;
            sat_ff    <= 1'b0;
            out_valid <= 1'b1;
         end else if (out_ready) begin
            out_valid <= 1'b0;
         end
      end
   end
endmodule

// ===== design/ida_checker.sv =====
// Port-level checker for the I-divergence accumulator, bound to the top level.
`include "assert_macros.svh"
module ida_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_mean,
   input logic [31:0] rsp_total
);
   `IDA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
   `IDA_ASSERT_NOW(a_empty_mean, rsp_valid && rsp_total == 32'd0, rsp_mean == 64'd0, "nonzero mean for empty image")
   `IDA_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "ready right after a pixel transfer")
endmodule

bind i_divergence_accumulator_unit ida_checker u_ida_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_mean  (rsp_chan.mean_divergence),
   .rsp_total (rsp_chan.pixel_total)
);
